FILE: rtl/trdm_pkg.sv
// Shared types, constants and tables for the turret relative drive mixer.
// Used by every module of the block; depends on nothing.
package trdm_pkg;

   localparam int ANGLE_BITS_DEF = 13;
   localparam int ROTATOR_STAGES_DEF = 16;

   localparam int ENC_W = 13;
   localparam int STICK_W = 15;
   localparam int SPEED_W = 15;
   localparam int OUT_W = 16;
   localparam int KEY_W = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 15;

   localparam int DATA_W = 27;
   localparam int PHASE_W = 32;
   localparam int FRAC_BITS = 8;
   localparam int MAG_W = DATA_W - 1;
   localparam int GAIN_W = 15;
   localparam int PROD_W = MAG_W + GAIN_W;
   localparam int GAIN_SHIFT = 23;
   localparam logic [GAIN_W-1:0] INV_GAIN = 15'd19898;
   localparam int SAT_MAX = 32767;

   localparam int KEY_W_BIT = 0;
   localparam int KEY_S_BIT = 1;
   localparam int KEY_D_BIT = 2;
   localparam int KEY_A_BIT = 3;
   localparam int KEY_Q_BIT = 4;
   localparam int KEY_E_BIT = 5;
   localparam int KEY_SHIFT_BIT = 6;
   localparam int KEY_CTRL_BIT = 7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEFAULT_SPEED = 3'd0,
      CSR_SHIFT_SPEED   = 3'd1,
      CSR_CTRL_SPEED    = 3'd2,
      CSR_YAW_NEUTRAL   = 3'd3,
      CSR_DEAD_ZONE     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  x;
      logic signed [DATA_W-1:0]  y;
      logic signed [PHASE_W-1:0] z;
      logic signed [OUT_W-1:0]   r;
   } vec_type;

   function automatic logic [PHASE_W-1:0] atan_turn(input int unsigned idx);
      logic [PHASE_W-1:0] val;
      case (idx)
         0:  val = 32'd536870912;
         1:  val = 32'd316933406;
         2:  val = 32'd167458907;
         3:  val = 32'd85004756;
         4:  val = 32'd42667331;
         5:  val = 32'd21354465;
         6:  val = 32'd10680862;
         7:  val = 32'd5340245;
         8:  val = 32'd2670163;
         9:  val = 32'd1335087;
         10: val = 32'd667544;
         11: val = 32'd333772;
         12: val = 32'd166886;
         13: val = 32'd83443;
         14: val = 32'd41722;
         15: val = 32'd20861;
         16: val = 32'd10430;
         17: val = 32'd5215;
         18: val = 32'd2608;
         19: val = 32'd1304;
         20: val = 32'd652;
         21: val = 32'd326;
         22: val = 32'd163;
         23: val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

FILE: rtl/trdm_front.sv
// Front stage: key mixing with saturation, yaw angle and coarse quarter turn.
// Depends on trdm_pkg.
module trdm_front #(
   parameter int ANGLE_BITS = trdm_pkg::ANGLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [trdm_pkg::STICK_W-1:0]   stick_x,
   input  logic signed [trdm_pkg::STICK_W-1:0]   stick_y,
   input  logic signed [trdm_pkg::STICK_W-1:0]   stick_r,
   input  logic [trdm_pkg::KEY_W-1:0]            key_mask,
   input  logic [trdm_pkg::ENC_W-1:0]            yaw_encoder,
   input  logic [trdm_pkg::SPEED_W-1:0]          default_speed,
   input  logic [trdm_pkg::SPEED_W-1:0]          shift_speed,
   input  logic [trdm_pkg::SPEED_W-1:0]          ctrl_speed,
   input  logic [trdm_pkg::ENC_W-1:0]            yaw_neutral,
   output logic                                  out_valid,
   output trdm_pkg::vec_type                     out_vec
);

   localparam int ENC_W = trdm_pkg::ENC_W;
   localparam int PW = trdm_pkg::PHASE_W;

   logic                               valid_ff, valid_in;
   trdm_pkg::vec_type                  vec_ff, vec_in;
   logic [trdm_pkg::SPEED_W-1:0]       speed;
   logic signed [trdm_pkg::OUT_W-1:0]  mx, my, mr, rx, ry;
   logic [ENC_W-1:0]                   delta;
   logic [ANGLE_BITS-1:0]              delta_q;
   logic [PW-1:0]                      phase, phase_sum, resid;
   logic [1:0]                         quad;

   function automatic logic signed [trdm_pkg::OUT_W-1:0] mix(
      input logic signed [trdm_pkg::STICK_W-1:0] s,
      input logic up,
      input logic dn,
      input logic [trdm_pkg::SPEED_W-1:0] spd
   );
      logic signed [16:0] term;
      logic signed [16:0] sum;
      logic signed [trdm_pkg::OUT_W-1:0] res;
      if (up && !dn) begin
         term = $signed({2'b00, spd});
      end else if (dn && !up) begin
         term = -$signed({2'b00, spd});
      end else begin
         term = '0;
      end
      sum = $signed({{2{s[trdm_pkg::STICK_W-1]}}, s}) + term;
      if (sum > 17'sd32767) begin
         res = 16'sd32767;
      end else if (sum < -17'sd32767) begin
         res = -16'sd32767;
      end else begin
         res = sum[trdm_pkg::OUT_W-1:0];
      end
      return res;
   endfunction

   always_comb begin
      unique case ({key_mask[trdm_pkg::KEY_CTRL_BIT], key_mask[trdm_pkg::KEY_SHIFT_BIT]})
         2'b01:   speed = shift_speed;
         2'b10:   speed = ctrl_speed;
         default: speed = default_speed;
      endcase
   end

   assign mx = mix(stick_x, key_mask[trdm_pkg::KEY_W_BIT], key_mask[trdm_pkg::KEY_S_BIT], speed);
   assign my = mix(stick_y, key_mask[trdm_pkg::KEY_D_BIT], key_mask[trdm_pkg::KEY_A_BIT], speed);
   assign mr = mix(stick_r, key_mask[trdm_pkg::KEY_Q_BIT], key_mask[trdm_pkg::KEY_E_BIT], speed);

   assign delta = yaw_encoder - yaw_neutral;

   generate
      if (ANGLE_BITS >= ENC_W) begin : g_up
         assign delta_q = ANGLE_BITS'(delta) << (ANGLE_BITS - ENC_W);
      end else begin : g_dn
         assign delta_q = ANGLE_BITS'(delta >> (ENC_W - ANGLE_BITS));
      end
   endgenerate

   assign phase = PW'(delta_q) << (PW - ANGLE_BITS);
   assign phase_sum = phase + 32'h2000_0000;
   assign quad = phase_sum[PW-1:PW-2];
   assign resid = phase - {quad, {(PW-2){1'b0}}};

   always_comb begin
      case (quad)
         2'd1: begin
            rx = -my;
            ry = mx;
         end
         2'd2: begin
            rx = -mx;
            ry = -my;
         end
         2'd3: begin
            rx = my;
            ry = -mx;
         end
         default: begin
            rx = mx;
            ry = my;
         end
      endcase
   end

   always_comb begin
      valid_in = in_valid;
      vec_in.x = $signed({{(trdm_pkg::DATA_W - trdm_pkg::OUT_W - trdm_pkg::FRAC_BITS){rx[15]}},
                          rx, {trdm_pkg::FRAC_BITS{1'b0}}});
      vec_in.y = $signed({{(trdm_pkg::DATA_W - trdm_pkg::OUT_W - trdm_pkg::FRAC_BITS){ry[15]}},
                          ry, {trdm_pkg::FRAC_BITS{1'b0}}});
      vec_in.z = $signed(resid);
      vec_in.r = mr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      vec_ff <= vec_in;
   end

   assign out_valid = valid_ff;
   assign out_vec = vec_ff;

endmodule

FILE: rtl/trdm_cell.sv
// One rotator cell: a single shift-and-add micro-rotation, registered.
// Depends on trdm_pkg for the item type and the arctangent table.
module trdm_cell #(
   parameter int STAGE = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  trdm_pkg::vec_type  in_vec,
   output logic               out_valid,
   output trdm_pkg::vec_type  out_vec
);

   localparam logic signed [trdm_pkg::PHASE_W-1:0] ANGLE = $signed(trdm_pkg::atan_turn(STAGE));

   logic                               valid_ff, valid_in;
   trdm_pkg::vec_type                  vec_ff, vec_in;
   logic signed [trdm_pkg::DATA_W-1:0] dx, dy;

   assign dx = in_vec.y >>> STAGE;
   assign dy = in_vec.x >>> STAGE;

   always_comb begin
      valid_in = in_valid;
      vec_in.r = in_vec.r;
      if (!in_vec.z[trdm_pkg::PHASE_W-1]) begin
         vec_in.x = in_vec.x - dx;
         vec_in.y = in_vec.y + dy;
         vec_in.z = in_vec.z - ANGLE;
      end else begin
         vec_in.x = in_vec.x + dx;
         vec_in.y = in_vec.y - dy;
         vec_in.z = in_vec.z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      vec_ff <= vec_in;
   end

   assign out_valid = valid_ff;
   assign out_vec = vec_ff;

endmodule

FILE: rtl/trdm_back.sv
// Back end: gain correction multiply, rounding, saturation and dead zone.
// Two register stages; depends on trdm_pkg.
module trdm_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  trdm_pkg::vec_type                    in_vec,
   input  logic [trdm_pkg::SPEED_W-1:0]         dead_zone,
   output logic                                 out_valid,
   output logic signed [trdm_pkg::OUT_W-1:0]    drive_x,
   output logic signed [trdm_pkg::OUT_W-1:0]    drive_y,
   output logic signed [trdm_pkg::OUT_W-1:0]    drive_r
);

   localparam int MW = trdm_pkg::MAG_W;
   localparam int PW = trdm_pkg::PROD_W;
   localparam int OW = trdm_pkg::OUT_W;

   logic                        valid1_ff, valid1_in, valid2_ff, valid2_in;
   logic [PW-1:0]               prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic                        neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic signed [OW-1:0]        r_ff, r_in;
   logic [MW-1:0]               mag_x, mag_y;
   logic signed [trdm_pkg::DATA_W-1:0] abs_x, abs_y;
   logic signed [OW-1:0]        drive_x_ff, drive_x_in, drive_y_ff, drive_y_in;
   logic signed [OW-1:0]        drive_r_ff, drive_r_in;
   logic [OW-1:0]               mag_r;

   function automatic logic signed [OW-1:0] finish(
      input logic [PW-1:0] prod,
      input logic neg,
      input logic [trdm_pkg::SPEED_W-1:0] dz
   );
      logic [PW-1:0]    rnd;
      logic [PW-trdm_pkg::GAIN_SHIFT-1:0] shr;
      logic [14:0]      mag;
      logic signed [OW-1:0] val;
      rnd = prod + (PW'(1) << (trdm_pkg::GAIN_SHIFT - 1));
      shr = rnd[PW-1:trdm_pkg::GAIN_SHIFT];
      if (shr > (PW-trdm_pkg::GAIN_SHIFT)'(trdm_pkg::SAT_MAX)) begin
         mag = 15'(trdm_pkg::SAT_MAX);
      end else begin
         mag = shr[14:0];
      end
      if (mag < dz) begin
         val = '0;
      end else if (neg) begin
         val = -$signed({1'b0, mag});
      end else begin
         val = $signed({1'b0, mag});
      end
      return val;
   endfunction

   assign abs_x = in_vec.x[trdm_pkg::DATA_W-1] ? -in_vec.x : in_vec.x;
   assign abs_y = in_vec.y[trdm_pkg::DATA_W-1] ? -in_vec.y : in_vec.y;
   assign mag_x = abs_x[MW-1:0];
   assign mag_y = abs_y[MW-1:0];

   always_comb begin
      valid1_in = in_valid;
      prod_x_in = PW'(mag_x) * PW'(trdm_pkg::INV_GAIN);
      prod_y_in = PW'(mag_y) * PW'(trdm_pkg::INV_GAIN);
      neg_x_in = in_vec.x[trdm_pkg::DATA_W-1];
      neg_y_in = in_vec.y[trdm_pkg::DATA_W-1];
      r_in = in_vec.r;
   end

   assign mag_r = r_ff[OW-1] ? 16'(-r_ff) : 16'(r_ff);

   always_comb begin
      valid2_in = valid1_ff;
      drive_x_in = finish(prod_x_ff, neg_x_ff, dead_zone);
      drive_y_in = finish(prod_y_ff, neg_y_ff, dead_zone);
      drive_r_in = (mag_r < {1'b0, dead_zone}) ? '0 : r_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
      end
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
      r_ff <= r_in;
      drive_x_ff <= drive_x_in;
      drive_y_ff <= drive_y_in;
      drive_r_ff <= drive_r_in;
   end

   assign out_valid = valid2_ff;
   assign drive_x = drive_x_ff;
   assign drive_y = drive_y_ff;
   assign drive_r = drive_r_ff;

endmodule

FILE: rtl/turret_relative_drive_mixer.sv
// Turret relative drive mixer: key mixing, yaw rotation and dead zone.
// The pipeline is the front stage, then ROTATOR_STAGES rotator cells, then the
// gain multiply and the final rounding registers of the back end. One item is taken every
// cycle and busy is always low; results are strobed by rsp_valid.
// Synchronous reset empties the pipeline and restores the register defaults.
// Depends on trdm_pkg, trdm_front, trdm_cell and trdm_back.
module turret_relative_drive_mixer #(
   parameter int ANGLE_BITS = trdm_pkg::ANGLE_BITS_DEF,
   parameter int ROTATOR_STAGES = trdm_pkg::ROTATOR_STAGES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [trdm_pkg::STICK_W-1:0]  req_stick_x,
   input  logic signed [trdm_pkg::STICK_W-1:0]  req_stick_y,
   input  logic signed [trdm_pkg::STICK_W-1:0]  req_stick_r,
   input  logic [trdm_pkg::KEY_W-1:0]           req_key_mask,
   input  logic [trdm_pkg::ENC_W-1:0]           req_yaw_encoder,
   output logic                                 rsp_valid,
   output logic signed [trdm_pkg::OUT_W-1:0]    rsp_drive_x,
   output logic signed [trdm_pkg::OUT_W-1:0]    rsp_drive_y,
   output logic signed [trdm_pkg::OUT_W-1:0]    rsp_drive_r,
   input  logic                                 csr_we,
   input  logic [trdm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [trdm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [trdm_pkg::SPEED_W-1:0] default_speed_ff, shift_speed_ff, ctrl_speed_ff, dead_zone_ff;
   logic [trdm_pkg::ENC_W-1:0]   yaw_neutral_ff;

   logic              chain_valid [0:ROTATOR_STAGES];
   trdm_pkg::vec_type chain_vec   [0:ROTATOR_STAGES];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_speed_ff <= 15'd8192;
         shift_speed_ff <= 15'd16384;
         ctrl_speed_ff <= 15'd4096;
         yaw_neutral_ff <= '0;
         dead_zone_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            trdm_pkg::CSR_DEFAULT_SPEED: default_speed_ff <= csr_wdata;
            trdm_pkg::CSR_SHIFT_SPEED:   shift_speed_ff <= csr_wdata;
            trdm_pkg::CSR_CTRL_SPEED:    ctrl_speed_ff <= csr_wdata;
            trdm_pkg::CSR_YAW_NEUTRAL:   yaw_neutral_ff <= csr_wdata[trdm_pkg::ENC_W-1:0];
            trdm_pkg::CSR_DEAD_ZONE:     dead_zone_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   trdm_front #(
      .ANGLE_BITS(ANGLE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (start & ~busy),
      .stick_x       (req_stick_x),
      .stick_y       (req_stick_y),
      .stick_r       (req_stick_r),
      .key_mask      (req_key_mask),
      .yaw_encoder   (req_yaw_encoder),
      .default_speed (default_speed_ff),
      .shift_speed   (shift_speed_ff),
      .ctrl_speed    (ctrl_speed_ff),
      .yaw_neutral   (yaw_neutral_ff),
      .out_valid     (chain_valid[0]),
      .out_vec       (chain_vec[0])
   );

   generate
      for (genvar i = 0; i < ROTATOR_STAGES; i++) begin : g_cell
         trdm_cell #(
            .STAGE(i)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (chain_valid[i]),
            .in_vec    (chain_vec[i]),
            .out_valid (chain_valid[i+1]),
            .out_vec   (chain_vec[i+1])
         );
      end
   endgenerate

   trdm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[ROTATOR_STAGES]),
      .in_vec    (chain_vec[ROTATOR_STAGES]),
      .dead_zone (dead_zone_ff),
      .out_valid (rsp_valid),
      .drive_x   (rsp_drive_x),
      .drive_y   (rsp_drive_y),
      .drive_r   (rsp_drive_r)
   );

endmodule
